// ----- rtl/core/power_alarm_sleep_monitor_macros.svh -----
// Assertion macros for the power alarm and sleep monitor.
`ifndef POWER_ALARM_SLEEP_MONITOR_MACROS_SVH
`define POWER_ALARM_SLEEP_MONITOR_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define PASM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define PASM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pasm_pkg.sv -----
// Shared constants and types for the power alarm and sleep monitor.
`timescale 1ns / 1ps
package pasm_pkg;

  localparam int MvW      = 12;
  localparam int TimeW    = 48;
  localparam int PowerW   = 15;
  localparam int LimitW   = 32;
  localparam int SpanW    = 24;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic signed [LimitW-1:0] PowerLimitRst = 32'sd10000000;
  localparam logic [MvW-1:0]           RangeSwitchRst  = 12'd1000;
  localparam logic [MvW-1:0]           QuietVoltageRst = 12'd200;
  localparam logic [MvW-1:0]           QuietCurrentRst = 12'd200;
  localparam logic [SpanW-1:0]         SleepEntryRst   = 24'd30000;

  localparam logic [TimeW-1:0] BreachSteadyMs = 48'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POWER_LIMIT   = 3'd0,
    CFG_RANGE_SWITCH  = 3'd1,
    CFG_QUIET_VOLTAGE = 3'd2,
    CFG_QUIET_CURRENT = 3'd3,
    CFG_SLEEP_ENTRY   = 3'd4
  } pasm_cfg_idx_e;

  // One sample after the power divide, ready for the state update.
  typedef struct packed {
    logic [MvW-1:0]    cur;
    logic [PowerW-1:0] power;
    logic [TimeW-1:0]  now;
    logic              quiet;
    logic              phase;
  } pasm_sample_t;

  typedef struct packed {
    logic over_power;
    logic buzzer_on;
    logic sleeping;
    logic sleep_entered;
    logic sleep_left;
  } pasm_flags_t;

endpackage

// ----- rtl/core/pasm_if.sv -----
// Request channel interfaces: samples in, results out, configuration writes.
`timescale 1ns / 1ps
interface pasm_sample_if import pasm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MvW-1:0]   current_high_mv;
  logic [MvW-1:0]   current_low_mv;
  logic [MvW-1:0]   volt_mv;
  logic [TimeW-1:0] time_ms;

  modport source (output valid, current_high_mv, current_low_mv, volt_mv, time_ms,
                  input ready);
  modport sink (input valid, current_high_mv, current_low_mv, volt_mv, time_ms,
                output ready);
endinterface

interface pasm_result_if import pasm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MvW-1:0]    selected_current_mv;
  logic [PowerW-1:0] pwr_mw;
  logic              over_power;
  logic              buzzer_on;
  logic              sleeping;
  logic              sleep_entered;
  logic              sleep_left;

  modport source (output valid, selected_current_mv, pwr_mw, over_power, buzzer_on,
                  sleeping, sleep_entered, sleep_left, input ready);
  modport sink (input valid, selected_current_mv, pwr_mw, over_power, buzzer_on,
                sleeping, sleep_entered, sleep_left, output ready);
endinterface

interface pasm_cfg_if import pasm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/pasm_alarm.sv -----
// Alarm and sleep state: breach tracking, buzzer pattern, quiet timer.
`timescale 1ns / 1ps
module pasm_alarm import pasm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     upd_i,
  input  pasm_sample_t             sample_i,
  input  logic signed [LimitW-1:0] limit_i,
  input  logic [SpanW-1:0]         entry_i,
  output pasm_flags_t              flags_o
);

  logic             alarm_q, alarm_d;
  logic [TimeW-1:0] breach_q, breach_d;
  logic             sleep_q, sleep_d;
  logic [TimeW-1:0] quiet_since_q, quiet_since_d;
  logic             over;

  // now - since >= span, with a backwards step counting as not reached
  function automatic logic at_least(input logic [TimeW-1:0] now,
                                    input logic [TimeW-1:0] since,
                                    input logic [TimeW-1:0] span);
    logic [TimeW-1:0] diff;
    diff = now - since;
    return (now >= since) && (diff >= span);
  endfunction

  always_comb begin
    over     = $signed({{(LimitW-PowerW){1'b0}}, sample_i.power}) > limit_i;
    alarm_d  = over;
    breach_d = (over && !alarm_q) ? sample_i.now : breach_q;

    flags_o.over_power = alarm_d;
    flags_o.buzzer_on  = alarm_d &&
                         (at_least(sample_i.now, breach_d, BreachSteadyMs) || sample_i.phase);

    sleep_d       = sleep_q;
    quiet_since_d = quiet_since_q;
    flags_o.sleep_entered = 1'b0;
    flags_o.sleep_left    = 1'b0;
    if (sample_i.quiet) begin
      if (!sleep_q) begin
        if (quiet_since_q == '0) begin
          quiet_since_d = sample_i.now;
        end else if (at_least(sample_i.now, quiet_since_q,
                              {{(TimeW-SpanW){1'b0}}, entry_i})) begin
          sleep_d               = 1'b1;
          quiet_since_d         = '0;
          flags_o.sleep_entered = 1'b1;
        end
      end
    end else begin
      quiet_since_d = '0;
      if (sleep_q) begin
        sleep_d            = 1'b0;
        flags_o.sleep_left = 1'b1;
      end
    end
    flags_o.sleeping = sleep_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q       <= 1'b0;
      breach_q      <= '0;
      sleep_q       <= 1'b0;
      quiet_since_q <= '0;
    end else if (upd_i) begin
      alarm_q       <= alarm_d;
      breach_q      <= breach_d;
      sleep_q       <= sleep_d;
      quiet_since_q <= quiet_since_d;
    end
  end

endmodule

// ----- rtl/core/power_alarm_sleep_monitor.sv -----
// Top level of the power alarm and low-activity sleep monitor.
// A request passes stage 1, stage 2, stage 3 and the output register before its result is presented.
// Throughput: one request per cycle; the input stage takes a new request
// whenever some stage of the 4-deep pipe (3 work stages, output register) is empty or the result is taken.
// Reset: async active-low; clears valids, alarm and sleep state, and loads
// the configuration registers with their defaults.
`timescale 1ns / 1ps
module power_alarm_sleep_monitor import pasm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  pasm_sample_if.sink  sample_i,
  pasm_result_if.source result_o,
  pasm_cfg_if.sink     cfg_i
);

  // floor(q / 125) for q < 2^21: q * ceil(2^28 / 125) >> 28
  localparam int                DivShift = 28;
  localparam int                QW       = 21;
  localparam int                RecipW   = 22;
  localparam logic [RecipW-1:0] Recip125 = 22'd2147484;

  // ---------------- configuration registers ----------------
  logic signed [LimitW-1:0] limit_q;
  logic [MvW-1:0]           range_sw_q;
  logic [MvW-1:0]           quiet_v_q;
  logic [MvW-1:0]           quiet_c_q;
  logic [SpanW-1:0]         entry_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= PowerLimitRst;
      range_sw_q <= RangeSwitchRst;
      quiet_v_q  <= QuietVoltageRst;
      quiet_c_q  <= QuietCurrentRst;
      entry_q    <= SleepEntryRst;
    end else if (cfg_i.valid) begin
      unique case (pasm_cfg_idx_e'(cfg_i.index))
        CFG_POWER_LIMIT:   limit_q    <= $signed(cfg_i.data[LimitW-1:0]);
        CFG_RANGE_SWITCH:  range_sw_q <= cfg_i.data[MvW-1:0];
        CFG_QUIET_VOLTAGE: quiet_v_q  <= cfg_i.data[MvW-1:0];
        CFG_QUIET_CURRENT: quiet_c_q  <= cfg_i.data[MvW-1:0];
        CFG_SLEEP_ENTRY:   entry_q    <= cfg_i.data[SpanW-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  // Each stage moves when the one after it is empty or moving, so bubbles
  // collapse and a waiting result blocks new requests only once every stage is full.
  logic v1_q, v2_q, v3_q, out_v_q;
  logic out_free, rdy3, rdy2, rdy1;

  assign out_free       = !out_v_q || result_o.ready;
  assign rdy3           = !v3_q || out_free;
  assign rdy2           = !v2_q || rdy3;
  assign rdy1           = !v1_q || rdy2;
  assign sample_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1)     v1_q    <= sample_i.valid;
      if (rdy2)     v2_q    <= v1_q;
      if (rdy3)     v3_q    <= v2_q;
      if (out_free) out_v_q <= v3_q;
    end
  end

  // ---------------- stage 1: captured request ----------------
  logic [MvW-1:0]   ch1_q, cl1_q, v1mv_q;
  logic [TimeW-1:0] t1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && sample_i.valid) begin
      ch1_q  <= sample_i.current_high_mv;
      cl1_q  <= sample_i.current_low_mv;
      v1mv_q <= sample_i.volt_mv;
      t1_q   <= sample_i.time_ms;
    end
  end

  // Beep phase is bit 0 of time / 125. With r = time mod 125 that bit is
  // r[0] ^ time[0]. The mod folds bytes by 256^i mod 125 (1,6,36,91,46,26).
  function automatic logic beep_phase(input logic [TimeW-1:0] t);
    logic [15:0] s;
    logic [10:0] f1;
    logic [8:0]  f2;
    logic [8:0]  r;
    s  = 16'(t[7:0]) + 16'(t[15:8]) * 16'd6 + 16'(t[23:16]) * 16'd36
       + 16'(t[31:24]) * 16'd91 + 16'(t[39:32]) * 16'd46 + 16'(t[47:40]) * 16'd26;
    f1 = 11'(s[7:0]) + 11'(s[15:8]) * 11'd6;
    f2 = 9'(f1[7:0]) + 9'(f1[10:8]) * 9'd6;
    if (f2 >= 9'd250)      r = f2 - 9'd250;
    else if (f2 >= 9'd125) r = f2 - 9'd125;
    else                   r = f2;
    return r[0] ^ t[0];
  endfunction

  // range switch, product, quiet test, beep phase
  logic [MvW-1:0]   cur1;
  logic [2*MvW-1:0] prod1;
  logic             quiet1, phase1;

  always_comb begin
    cur1   = (ch1_q < range_sw_q) ? cl1_q : ch1_q;
    prod1  = (2*MvW)'(v1mv_q) * (2*MvW)'(cur1);
    quiet1 = (v1mv_q < quiet_v_q) && (cur1 < quiet_c_q);
    phase1 = beep_phase(t1_q);
  end

  // ---------------- stage 2: product ----------------
  logic [MvW-1:0]   cur2_q;
  logic [2*MvW-1:0] prod2_q;
  logic [TimeW-1:0] t2_q;
  logic             quiet2_q, phase2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      cur2_q   <= cur1;
      prod2_q  <= prod1;
      t2_q     <= t1_q;
      quiet2_q <= quiet1;
      phase2_q <= phase1;
    end
  end

  // divide by 1000: drop 3 bits, then the reciprocal multiply for 125
  logic [QW-1:0]        q2;
  logic [QW+RecipW-1:0] mq2;
  logic [PowerW-1:0]    pw2;

  always_comb begin
    q2  = prod2_q[2*MvW-1:3];
    mq2 = (QW+RecipW)'(q2) * (QW+RecipW)'(Recip125);
    pw2 = mq2[DivShift +: PowerW];
  end

  // ---------------- stage 3: power ----------------
  pasm_sample_t s3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_q.cur   <= cur2_q;
      s3_q.power <= pw2;
      s3_q.now   <= t2_q;
      s3_q.quiet <= quiet2_q;
      s3_q.phase <= phase2_q;
    end
  end

  // state update happens as the sample moves into the output register
  pasm_flags_t flags3;
  logic        adv3;

  assign adv3 = v3_q && out_free;

  pasm_alarm u_alarm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (adv3),
    .sample_i (s3_q),
    .limit_i  (limit_q),
    .entry_i  (entry_q),
    .flags_o  (flags3)
  );

  // ---------------- output register ----------------
  logic [MvW-1:0]    out_cur_q;
  logic [PowerW-1:0] out_pw_q;
  pasm_flags_t       out_flags_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      out_cur_q   <= s3_q.cur;
      out_pw_q    <= s3_q.power;
      out_flags_q <= flags3;
    end
  end

  assign result_o.valid               = out_v_q;
  assign result_o.selected_current_mv = out_cur_q;
  assign result_o.pwr_mw              = out_pw_q;
  assign result_o.over_power          = out_flags_q.over_power;
  assign result_o.buzzer_on           = out_flags_q.buzzer_on;
  assign result_o.sleeping            = out_flags_q.sleeping;
  assign result_o.sleep_entered       = out_flags_q.sleep_entered;
  assign result_o.sleep_left          = out_flags_q.sleep_left;

endmodule

// ----- rtl/core/pasm_checker.sv -----
// Port-level checks for the power alarm and sleep monitor, bound to the top.
`timescale 1ns / 1ps
`include "power_alarm_sleep_monitor_macros.svh"
module pasm_checker import pasm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [PowerW-1:0] pwr_mw_i,
  input logic              over_power_i,
  input logic              buzzer_on_i,
  input logic              sleeping_i,
  input logic              sleep_entered_i,
  input logic              sleep_left_i
);

  `PASM_ASSERT_NOW(a_buzz_needs_alarm, clk_i, rst_ni, res_valid_i && buzzer_on_i, over_power_i, "buzzer on without over-power")
  `PASM_ASSERT_NOW(a_enter_sleeping, clk_i, rst_ni, res_valid_i && sleep_entered_i, sleeping_i && !sleep_left_i, "sleep entry not reflected")
  `PASM_ASSERT_NOW(a_leave_awake, clk_i, rst_ni, res_valid_i && sleep_left_i, !sleeping_i, "sleep exit not reflected")
  `PASM_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(pwr_mw_i) && $stable(sleeping_i), "stalled result changed")

endmodule

bind power_alarm_sleep_monitor pasm_checker u_pasm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (result_o.valid),
  .res_ready_i     (result_o.ready),
  .pwr_mw_i        (result_o.pwr_mw),
  .over_power_i    (result_o.over_power),
  .buzzer_on_i     (result_o.buzzer_on),
  .sleeping_i      (result_o.sleeping),
  .sleep_entered_i (result_o.sleep_entered),
  .sleep_left_i    (result_o.sleep_left)
);

// ----- tb/tb_power_alarm_sleep_monitor.sv -----
// Self-checking testbench for the power alarm and low-activity sleep monitor.
`timescale 1ns / 1ps
module tb_power_alarm_sleep_monitor;
  import pasm_pkg::*;

  // Drain margin after the last result, before a register write or the end.
  localparam int DrainCycles  = 6;
  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int StallLimit   = 5000;
  localparam int Segments     = 8;
  localparam int SegmentItems = 153;
  localparam int ShowLimit    = 10;

  localparam int unsigned PowerDiv   = 1000;
  localparam int unsigned BeepHalfMs = 125;
  localparam int unsigned SteadyMs   = 1000;

  typedef struct packed {
    logic [MvW-1:0]   cur_high;
    logic [MvW-1:0]   cur_low;
    logic [MvW-1:0]   volt;
    logic [TimeW-1:0] stamp;
  } reading_t;

  // Flag order in typed rows: over, buzz, asleep, entered, left.
  typedef struct packed {
    logic [MvW-1:0]    cur;
    logic [PowerW-1:0] power;
    logic              over;
    logic              buzz;
    logic              asleep;
    logic              entered;
    logic              left;
  } verdict_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  // One line of the directed plan: a register write or a request.
  typedef struct packed {
    row_kind_e           kind;
    pasm_cfg_idx_e       idx;
    logic [CfgDataW-1:0] data;
    reading_t            rd;
    logic                known;
    verdict_t            res;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pasm_sample_if sample_if ();
  pasm_result_if result_if ();
  pasm_cfg_if    cfg_if ();

  power_alarm_sleep_monitor dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the settings, as the block holds them.
  int               lim_mw;
  logic [MvW-1:0]   switch_mv;
  logic [MvW-1:0]   quiet_v_mv;
  logic [MvW-1:0]   quiet_i_mv;
  logic [SpanW-1:0] sleep_span_ms;

  // Shadow copy of the alarm and sleep state.
  logic             alarm_on;
  logic [TimeW-1:0] breach_t0;
  logic             asleep;
  logic [TimeW-1:0] quiet_t0;   // zero: quiet timer not running

  verdict_t  pending[$];        // results owed by the block, oldest first
  plan_row_t plan[$];

  int failures     = 0;
  int stall_cycles = 0;
  int idle_pct     = 0;         // chance the sender holds off a request
  int stall_pct    = 0;         // chance the receiver holds off ready

  // Elapsed time counts as negative when the clock has gone backwards.
  function automatic logic span_reached(logic [TimeW-1:0] now, logic [TimeW-1:0] since,
                                        logic [TimeW-1:0] span);
    return (now >= since) && ((now - since) >= span);
  endfunction

  // Advance the shadow state by one request and return the result it owes.
  function automatic verdict_t predict_reading(reading_t rd);
    verdict_t         vr;
    int unsigned      cur_u;
    int unsigned      volt_u;
    int unsigned      pw_u;
    logic [TimeW-1:0] slot;
    logic             quiet;
    cur_u  = 32'((rd.cur_high < switch_mv) ? rd.cur_low : rd.cur_high);
    volt_u = 32'(rd.volt);
    pw_u   = (volt_u * cur_u) / PowerDiv;
    vr       = '0;
    vr.cur   = cur_u[MvW-1:0];
    vr.power = pw_u[PowerW-1:0];

    // Breach start is latched only on the rising edge of the alarm.
    if (int'(pw_u) > lim_mw) begin
      if (!alarm_on) begin
        alarm_on  = 1'b1;
        breach_t0 = rd.stamp;
      end
    end else begin
      alarm_on = 1'b0;
    end
    if (alarm_on) begin
      slot    = rd.stamp / TimeW'(BeepHalfMs);
      vr.buzz = span_reached(rd.stamp, breach_t0, TimeW'(SteadyMs)) ? 1'b1 : slot[0];
    end

    // Quiet timer; a quiet sample at time zero cannot start it.
    quiet = (rd.volt < quiet_v_mv) && (cur_u[MvW-1:0] < quiet_i_mv);
    if (quiet) begin
      if (!asleep) begin
        if (quiet_t0 == '0) begin
          quiet_t0 = rd.stamp;
        end else if (span_reached(rd.stamp, quiet_t0, TimeW'(sleep_span_ms))) begin
          asleep     = 1'b1;
          quiet_t0   = '0;
          vr.entered = 1'b1;
        end
      end
    end else begin
      quiet_t0 = '0;
      if (asleep) begin
        asleep  = 1'b0;
        vr.left = 1'b1;
      end
    end
    vr.over   = alarm_on;
    vr.asleep = asleep;
    return vr;
  endfunction

  function automatic void plan_write(pasm_cfg_idx_e idx, logic [CfgDataW-1:0] data);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    plan.push_back(row);
  endfunction

  function automatic void plan_reading(logic [MvW-1:0] ch, logic [MvW-1:0] cl,
                                       logic [MvW-1:0] v, logic [TimeW-1:0] t,
                                       logic known, verdict_t res);
    plan_row_t row;
    row             = '0;
    row.kind        = ROW_SAMPLE;
    row.idx         = CFG_POWER_LIMIT;
    row.rd.cur_high = ch;
    row.rd.cur_low  = cl;
    row.rd.volt     = v;
    row.rd.stamp    = t;
    row.known       = known;
    row.res         = res;
    plan.push_back(row);
  endfunction

  // Offer one request; the result is owed from the edge it is taken.
  // Valid stays high on return so back-to-back requests need no dip.
  task automatic send_reading(reading_t rd, logic known, verdict_t typed);
    verdict_t vr;
    if ($urandom_range(99) < idle_pct) begin
      sample_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    sample_if.valid           <= 1'b1;
    sample_if.current_high_mv <= rd.cur_high;
    sample_if.current_low_mv  <= rd.cur_low;
    sample_if.volt_mv         <= rd.volt;
    sample_if.time_ms         <= rd.stamp;
    do @(posedge clk_i); while (!sample_if.ready);
    vr = predict_reading(rd);
    pending.push_back(known ? typed : vr);
  endtask

  // Register writes only go out with the pipe empty.
  task automatic write_setting(pasm_cfg_idx_e idx, logic [CfgDataW-1:0] data);
    sample_if.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_POWER_LIMIT:   lim_mw        = int'(data);
      CFG_RANGE_SWITCH:  switch_mv     = data[MvW-1:0];
      CFG_QUIET_VOLTAGE: quiet_v_mv    = data[MvW-1:0];
      CFG_QUIET_CURRENT: quiet_i_mv    = data[MvW-1:0];
      CFG_SLEEP_ENTRY:   sleep_span_ms = data[SpanW-1:0];
      default: ;
    endcase
  endtask

  // Result side: random backpressure and an in-order compare.
  always @(posedge clk_i) begin : check_results
    verdict_t got;
    verdict_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = {result_if.selected_current_mv, result_if.pwr_mw, result_if.over_power,
             result_if.buzzer_on, result_if.sleeping, result_if.sleep_entered,
             result_if.sleep_left};
      if (pending.size() == 0) begin
        failures++;
        if (failures <= ShowLimit)
          $display("[%0t] result with nothing owed: cur=%0d pw=%0d flags=%b", $realtime,
                   got.cur, got.power, {got.over, got.buzz, got.asleep, got.entered,
                   got.left});
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= ShowLimit) begin
            $display("[%0t] mismatch, expected cur=%0d pw=%0d over=%b buzz=%b sleep=%b",
                     $realtime, want.cur, want.power, want.over, want.buzz, want.asleep);
            $display("    entered=%b left=%b; got cur=%0d pw=%0d over=%b buzz=%b sleep=%b",
                     want.entered, want.left, got.cur, got.power, got.over, got.buzz,
                     got.asleep);
            $display("    entered=%b left=%b", got.entered, got.left);
          end
        end
      end
    end
    result_if.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // Hang detector: any handshake on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_if.valid && sample_if.ready) ||
        (result_if.valid && result_if.ready) || (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    reading_t            rd;
    int                  burst_left;
    int                  mode;
    int                  roll;
    logic [63:0]         wide;
    logic [63:0]         jump;
    logic [CfgDataW-1:0] pick;
    logic [TimeW-1:0]    now_ms;

    sample_if.valid           <= 1'b0;
    sample_if.current_high_mv <= '0;
    sample_if.current_low_mv  <= '0;
    sample_if.volt_mv         <= '0;
    sample_if.time_ms         <= '0;
    cfg_if.valid              <= 1'b0;
    cfg_if.index              <= CFG_POWER_LIMIT;
    cfg_if.data               <= '0;

    // Register and state values after reset.
    lim_mw        = 10000000;
    switch_mv     = 12'd1000;
    quiet_v_mv    = 12'd200;
    quiet_i_mv    = 12'd200;
    sleep_span_ms = 24'd30000;
    alarm_on      = 1'b0;
    breach_t0     = '0;
    asleep        = 1'b0;
    quiet_t0      = '0;

    // Directed plan, reset settings first. Quiet at time zero starts nothing.
    plan_reading(12'd0, 12'd0, 12'd0, 48'd0, 1'b1, {12'd0, 15'd0, 5'b00000});
    plan_reading(12'd4095, 12'd0, 12'd4095, 48'd1, 1'b1, {12'd4095, 15'd16769, 5'b00000});
    // High reading just under the switch level picks the low channel.
    plan_reading(12'd999, 12'd4095, 12'd4095, 48'd2, 1'b1, {12'd4095, 15'd16769, 5'b00000});
    plan_reading(12'd1000, 12'd7, 12'd1000, 48'd3, 1'b1, {12'd1000, 15'd1000, 5'b00000});
    // Quiet span: start, one ms short, entry, quiet while asleep, wake.
    plan_reading(12'd0, 12'd100, 12'd100, 48'd10, 1'b1, {12'd100, 15'd10, 5'b00000});
    plan_reading(12'd0, 12'd100, 12'd100, 48'd30009, 1'b1, {12'd100, 15'd10, 5'b00000});
    plan_reading(12'd0, 12'd100, 12'd100, 48'd30010, 1'b1, {12'd100, 15'd10, 5'b00110});
    plan_reading(12'd0, 12'd100, 12'd100, 48'd40000, 1'b1, {12'd100, 15'd10, 5'b00100});
    plan_reading(12'd0, 12'd100, 12'd4095, 48'd40001, 1'b1, {12'd100, 15'd409, 5'b00001});
    // Clock running backwards holds off sleep entry.
    plan_reading(12'd0, 12'd5, 12'd5, 48'd50000, 1'b0, '0);
    plan_reading(12'd0, 12'd5, 12'd5, 48'd100, 1'b0, '0);
    plan_reading(12'd0, 12'd5, 12'd5, 48'd80000, 1'b0, '0);
    plan_reading(12'd2048, 12'd0, 12'd3000, 48'hFFFF_FFFF_FFFF, 1'b0, '0);

    // Low limit, zero quiet span, everything below 4095 counts as quiet.
    plan_write(CFG_POWER_LIMIT, 32'd1000);
    plan_write(CFG_RANGE_SWITCH, 32'd4095);
    plan_write(CFG_QUIET_VOLTAGE, 32'd4095);
    plan_write(CFG_QUIET_CURRENT, 32'd4095);
    plan_write(CFG_SLEEP_ENTRY, 32'd0);
    plan_reading(12'd0, 12'd1000, 12'd1000, 48'd1000, 1'b0, '0);   // at the limit
    plan_reading(12'd0, 12'd1001, 12'd1000, 48'd1000, 1'b0, '0);   // breach onset
    plan_reading(12'd0, 12'd1001, 12'd1000, 48'd1125, 1'b0, '0);   // beep high
    plan_reading(12'd0, 12'd1001, 12'd1000, 48'd500, 1'b0, '0);    // backwards
    plan_reading(12'd0, 12'd1001, 12'd1000, 48'd2000, 1'b0, '0);   // steady tone
    plan_reading(12'd4095, 12'd0, 12'd4095, 48'd2001, 1'b0, '0);
    plan_reading(12'd0, 12'd0, 12'd0, 48'd2002, 1'b0, '0);         // back to normal

    // Most negative limit: zero power still breaches. Nothing can be quiet.
    plan_write(CFG_POWER_LIMIT, 32'h8000_0000);
    plan_write(CFG_RANGE_SWITCH, 32'd0);
    plan_write(CFG_QUIET_VOLTAGE, 32'd0);
    plan_write(CFG_QUIET_CURRENT, 32'd0);
    plan_reading(12'd0, 12'd4095, 12'd0, 48'd3000, 1'b1, {12'd0, 15'd0, 5'b10000});

    // Largest limit and the longest quiet span.
    plan_write(CFG_POWER_LIMIT, 32'h7FFF_FFFF);
    plan_write(CFG_RANGE_SWITCH, 32'd1000);
    plan_write(CFG_QUIET_VOLTAGE, 32'd200);
    plan_write(CFG_QUIET_CURRENT, 32'd200);
    plan_write(CFG_SLEEP_ENTRY, 32'h00FF_FFFF);
    plan_reading(12'd4095, 12'd4095, 12'd4095, 48'd3100, 1'b1,
                 {12'd4095, 15'd16769, 5'b00000});
    plan_reading(12'd0, 12'd0, 12'd0, 48'd3200, 1'b0, '0);
    plan_reading(12'd0, 12'd0, 12'd0, 48'd16780414, 1'b0, '0);
    plan_reading(12'd0, 12'd0, 12'd0, 48'd16780415, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_setting(plan[i].idx, plan[i].data);
      end else begin
        send_reading(plan[i].rd, plan[i].known, plan[i].res);
      end
    end

    // Random part: two segments per idling mode, fresh settings for each.
    // Bursts of quiet or loaded samples drive the sleep timer and the alarm
    // through their full sequences; noise bursts fill in the rest.
    now_ms     = 48'd16780416;
    burst_left = 0;
    mode       = 0;
    for (int seg = 0; seg < Segments; seg++) begin
      case (seg / 2)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 83; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase

      case ($urandom_range(9))
        0:       pick = 32'h8000_0000;
        1:       pick = 32'h7FFF_FFFF;
        2:       pick = '0;
        3:       pick = '1;
        default: pick = $urandom_range(17000);
      endcase
      write_setting(CFG_POWER_LIMIT, pick);
      case ($urandom_range(4))
        0:       pick = 32'd0;
        1:       pick = 32'd4095;
        default: pick = $urandom_range(4095);
      endcase
      write_setting(CFG_RANGE_SWITCH, pick);
      case ($urandom_range(4))
        0:       pick = 32'd0;
        1:       pick = 32'd4095;
        default: pick = $urandom_range(1200);
      endcase
      write_setting(CFG_QUIET_VOLTAGE, pick);
      case ($urandom_range(4))
        0:       pick = 32'd0;
        1:       pick = 32'd4095;
        default: pick = $urandom_range(1200);
      endcase
      write_setting(CFG_QUIET_CURRENT, pick);
      case ($urandom_range(5))
        0:       pick = 32'd0;
        1:       pick = 32'h00FF_FFFF;
        default: pick = $urandom_range(3000);
      endcase
      write_setting(CFG_SLEEP_ENTRY, pick);

      for (int n = 0; n < SegmentItems; n++) begin
        if (burst_left == 0) begin
          mode       = $urandom_range(2);   // 0 quiet, 1 loaded, 2 noise
          burst_left = $urandom_range(40, 1);
        end
        burst_left--;
        wide        = {$urandom, $urandom};
        rd.cur_high = wide[11:0];
        rd.cur_low  = wide[23:12];
        rd.volt     = wide[35:24];
        if (mode == 0 && quiet_v_mv != 0 && quiet_i_mv != 0) begin
          rd.volt = $urandom_range(quiet_v_mv - 1);
          // Reach a quiet current through either side of the range switch.
          if (switch_mv != 0 && ($urandom_range(1) == 1 || quiet_i_mv <= switch_mv)) begin
            rd.cur_high = $urandom_range(switch_mv - 1);
            rd.cur_low  = $urandom_range(quiet_i_mv - 1);
          end else begin
            rd.cur_high = $urandom_range(quiet_i_mv - 1, switch_mv);
          end
        end else if (mode == 1) begin
          rd.volt     = $urandom_range(4095, 2000);
          rd.cur_high = $urandom_range(4095, 1000);
        end

        // Mostly forward steps; now and then a step back or a wild jump.
        roll = $urandom_range(199);
        if (roll == 0) begin
          jump   = {$urandom, $urandom};
          now_ms = jump[TimeW-1:0];
        end else if (roll < 5) begin
          now_ms = now_ms - $urandom_range(3000);
        end else begin
          now_ms = now_ms + ((mode == 1) ? $urandom_range(150) : $urandom_range(300));
        end
        rd.stamp = now_ms;
        send_reading(rd, 1'b0, '0);
      end
    end

    sample_if.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
